### sv/cnmt_pkg.sv
// ---------------------------------------------------------------------------
// cnmt_pkg
// Shared types, field codes and widths of the CANopen NMT heartbeat supervisor.
// ---------------------------------------------------------------------------
`default_nettype none

package cnmt_pkg;

    localparam int TIME_BITS = 32;
    localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [TIME_BITS-1:0] time_t;

    // Event command codes.
    localparam logic [2:0] CMD_NMT       = 3'd0;
    localparam logic [2:0] CMD_HEARTBEAT = 3'd1;
    localparam logic [2:0] CMD_EMCY      = 3'd2;
    localparam logic [2:0] CMD_ARM       = 3'd3;
    localparam logic [2:0] CMD_POLL      = 3'd4;

    // NMT request codes.
    localparam logic [2:0] NMT_START       = 3'd0;
    localparam logic [2:0] NMT_STOP        = 3'd1;
    localparam logic [2:0] NMT_PREOP       = 3'd2;
    localparam logic [2:0] NMT_RESET_NODE  = 3'd3;
    localparam logic [2:0] NMT_RESET_COMM  = 3'd4;

    // Node states.
    localparam logic [1:0] ST_INIT    = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_PREOP   = 2'd2;
    localparam logic [1:0] ST_OPER    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_CONSUMER_ENABLED = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONSUMER_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRODUCER_PERIOD  = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  nmt_request;
        logic [1:0]  reported_state;
        logic [31:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0] node_state;
        logic       alive_flag;
        logic       emergency_flag;
        logic       timed_out;
        logic       produce_now;
        logic       was_reset;
        logic       node_reset_request;
    } out_item_t;

    // Handshake between the input register and the processing stage.
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } evt_stage_t;

endpackage

`default_nettype wire

### sv/cnmt_in_stage.sv
// ---------------------------------------------------------------------------
// cnmt_in_stage
// Input register: captures one event and holds it until the core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cnmt_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  cnmt_pkg::in_item_t     s_data,
    output cnmt_pkg::evt_stage_t   evt,
    input  wire logic              evt_take
);
    import cnmt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // A new beat may enter whenever the held one leaves in the same cycle.
    assign s_ready    = !valid_reg || evt_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !evt_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign evt.valid = valid_reg;
    assign evt.item  = item_reg;

endmodule

`default_nettype wire

### sv/cnmt_core.sv
// ---------------------------------------------------------------------------
// cnmt_core
// Node state, heartbeat timers and configuration; produces the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module cnmt_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  cnmt_pkg::evt_stage_t                   evt,
    output logic                                   evt_take,
    input  wire logic                              cfg_valid,
    input  wire logic [cnmt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [cnmt_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output cnmt_pkg::out_item_t                    m_data
);
    import cnmt_pkg::*;

    logic        consumer_enabled_reg;
    logic [31:0] consumer_timeout_reg;
    logic [31:0] producer_period_reg;

    logic [1:0]  state_reg,        state_next;
    logic        alive_reg,        alive_next;
    logic        emcy_reg,         emcy_next;
    logic        armed_reg,        armed_next;
    time_t       heard_time_reg,   heard_time_next;
    time_t       sent_time_reg,    sent_time_next;

    logic        out_valid_reg,    out_valid_next;
    out_item_t   out_reg,          out_next;

    time_t       now;
    time_t       since_heard;
    time_t       since_sent;
    logic        tout;
    logic        prod;

    assign evt_take = evt.valid && (!out_valid_reg || m_ready);

    assign now         = TIME_BITS'(evt.item.timestamp);
    assign since_heard = now - heard_time_reg;
    assign since_sent  = now - sent_time_reg;

    assign tout = consumer_enabled_reg && armed_reg &&
                  (CMP_BITS'(since_heard) > CMP_BITS'(consumer_timeout_reg));
    assign prod = (producer_period_reg != 32'd0) &&
                  (CMP_BITS'(since_sent) >= CMP_BITS'(producer_period_reg));

    always_comb begin
        state_next      = state_reg;
        alive_next      = alive_reg;
        emcy_next       = emcy_reg;
        armed_next      = armed_reg;
        heard_time_next = heard_time_reg;
        sent_time_next  = sent_time_reg;
        out_next        = '0;

        priority if (evt.item.command == CMD_NMT) begin
            priority if (evt.item.nmt_request == NMT_START) begin
                state_next = ST_OPER;
            end else if (evt.item.nmt_request == NMT_STOP) begin
                state_next = ST_STOPPED;
            end else if (evt.item.nmt_request == NMT_PREOP) begin
                state_next = ST_PREOP;
            end else if (evt.item.nmt_request == NMT_RESET_NODE ||
                         evt.item.nmt_request == NMT_RESET_COMM) begin
                state_next                  = ST_PREOP;
                alive_next                  = 1'b0;
                emcy_next                   = 1'b0;
                heard_time_next             = now;
                sent_time_next              = now;
                out_next.was_reset          = 1'b1;
                out_next.node_reset_request =
                    (evt.item.nmt_request == NMT_RESET_NODE);
            end else begin
                state_next = state_reg;
            end
        end else if (evt.item.command == CMD_HEARTBEAT) begin
            state_next      = evt.item.reported_state;
            heard_time_next = now;
            alive_next      = 1'b1;
        end else if (evt.item.command == CMD_EMCY) begin
            emcy_next = 1'b1;
        end else if (evt.item.command == CMD_ARM) begin
            sent_time_next = now;
            if (consumer_enabled_reg) begin
                armed_next      = 1'b1;
                heard_time_next = now;
            end
        end else if (evt.item.command == CMD_POLL) begin
            out_next.timed_out   = tout;
            out_next.produce_now = prod;
            if (prod) begin
                sent_time_next = now;
            end
        end else begin
            state_next = state_reg;
        end

        out_next.node_state     = state_next;
        out_next.alive_flag     = alive_next;
        out_next.emergency_flag = emcy_next;
    end

    assign out_valid_next = evt_take || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            consumer_enabled_reg <= 1'b0;
            consumer_timeout_reg <= '0;
            producer_period_reg  <= '0;
            state_reg            <= ST_PREOP;
            alive_reg            <= 1'b0;
            emcy_reg             <= 1'b0;
            armed_reg            <= 1'b0;
            heard_time_reg       <= '0;
            sent_time_reg        <= '0;
            out_valid_reg        <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_CONSUMER_ENABLED: consumer_enabled_reg <= cfg_data[0];
                    REG_CONSUMER_TIMEOUT: consumer_timeout_reg <= cfg_data;
                    REG_PRODUCER_PERIOD:  producer_period_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (evt_take) begin
                state_reg      <= state_next;
                alive_reg      <= alive_next;
                emcy_reg       <= emcy_next;
                armed_reg      <= armed_next;
                heard_time_reg <= heard_time_next;
                sent_time_reg  <= sent_time_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_take) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### sv/canopen_nmt_heartbeat_supervisor.sv
// ---------------------------------------------------------------------------
// canopen_nmt_heartbeat_supervisor
// Tracks the NMT state of one CANopen node and supervises its heartbeats.
// ---------------------------------------------------------------------------
//
//  Channel   Ports                               Direction  Beat
//  event     s_valid s_ready s_data              in         in_item_t
//  result    m_valid m_ready m_data              out        out_item_t
//  config    cfg_valid cfg_ready cfg_index/data  in         register write
//
//  One event is taken every cycle while result beats are accepted; its result
//  passes through the input register and then the result register.
//  The state update and both timer compares happen in one pass from the
//  input register to the result register.
//  Reset is synchronous and active low; the node restarts pre-operational.
//  When the result beat is not taken, the held event waits and s_ready drops.
//
`default_nettype none

module canopen_nmt_heartbeat_supervisor (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  cnmt_pkg::in_item_t                      s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output cnmt_pkg::out_item_t                     m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cnmt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [cnmt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import cnmt_pkg::*;

    evt_stage_t evt;
    logic       evt_take;

    assign cfg_ready = 1'b1;

    cnmt_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .evt      (evt),
        .evt_take (evt_take)
    );

    cnmt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt       (evt),
        .evt_take  (evt_take),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // The event side only stalls when a finished result is being held back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("event input stalled while the result register was free");

    // A reset result always shows the cleared communication state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.was_reset) |->
            (m_data.node_state == ST_PREOP && !m_data.alive_flag &&
             !m_data.emergency_flag && !m_data.timed_out && !m_data.produce_now))
        else $error("reset result does not show the cleared state");

    // A node reset request is only ever reported as part of a reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.node_reset_request) |-> m_data.was_reset)
        else $error("node reset request without a reset");

    // A result beat follows an event taken by the core in the cycle before.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(evt.valid))
        else $error("result beat without a preceding event");

endmodule

`default_nettype wire
